FILE: rtl/abrw_pkg.sv
// Package for the area border reflect/wrap block: payload types, register
// indexes, policy codes and pipeline constants. No dependencies.
package abrw_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DIV_STAGES = 32;

  // Heading mirror constant: 180 degrees in fixed point.
  localparam logic signed [33:0] HEAD_180 = 34'sd180 <<< FRAC_BITS;
  localparam logic signed [33:0] S32_MAX  = 34'sd2147483647;
  localparam logic signed [33:0] S32_MIN  = -34'sd2147483648;

  localparam logic [2:0] REG_MIN_X  = 3'd0;
  localparam logic [2:0] REG_MAX_X  = 3'd1;
  localparam logic [2:0] REG_MIN_Y  = 3'd2;
  localparam logic [2:0] REG_MAX_Y  = 3'd3;
  localparam logic [2:0] REG_MIN_Z  = 3'd4;
  localparam logic [2:0] REG_MAX_Z  = 3'd5;
  localparam logic [2:0] REG_POLICY = 3'd6;

  localparam logic [1:0] POL_REFLECT = 2'd0;
  localparam logic [1:0] POL_WRAP    = 2'd1;
  localparam logic [1:0] POL_ERROR   = 2'd2;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] heading;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_target_x;
    logic signed [31:0] new_target_y;
    logic signed [31:0] new_target_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic signed [31:0] new_heading;
    logic               outside_error;
  } out_item_t;

  // Per-axis facts carried alongside the divider lanes.
  typedef struct packed {
    logic               outside;
    logic               size_zero;
    logic               size_neg;
    logic               pos_neg;
    logic               tgt_neg;
    logic signed [32:0] size;
    logic signed [31:0] lo;
    logic signed [31:0] vel;
  } axis_side_t;

  typedef struct packed {
    axis_side_t [2:0]   axis;
    logic signed [31:0] heading;
    logic [1:0]         policy;
  } side_t;

  // Result of one fold lane.
  typedef struct packed {
    logic signed [31:0] value;
    logic               flip;
  } fold_res_t;

endpackage

FILE: rtl/abrw_if.sv
// Valid/ready channel interfaces for the input and result items.
// Depends on abrw_pkg for the payload types.
interface abrw_in_if import abrw_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface abrw_out_if import abrw_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/abrw_div.sv
// Pipelined unsigned 32-bit restoring divider, one quotient bit per stage.
// Depends on abrw_pkg; gives the remainder and the quotient's low bit.
module abrw_div import abrw_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic [31:0] rem,
  output logic        q_lsb
);

  logic [31:0] rem_r [DIV_STAGES];
  logic [31:0] num_r [DIV_STAGES];
  logic [31:0] den_r [DIV_STAGES];
  logic        qb_r  [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [31:0] rem_in, num_in, den_in;
    logic [32:0] trial;
    logic [32:0] diff;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign num_in = num_r[k-1];
      assign den_in = den_r[k-1];
    end

    // Shift in the next dividend bit and try a subtract.
    always_comb begin
      trial = {rem_in, num_in[31]};
      diff  = trial - {1'b0, den_in};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[32]) begin
          rem_r[k] <= diff[31:0];
          qb_r[k]  <= 1'b1;
        end else begin
          rem_r[k] <= trial[31:0];
          qb_r[k]  <= 1'b0;
        end
        num_r[k] <= {num_in[30:0], 1'b0};
        den_r[k] <= den_in;
      end
    end
  end

  assign rem   = rem_r[DIV_STAGES-1];
  assign q_lsb = qb_r[DIV_STAGES-1];

endmodule

FILE: rtl/abrw_fold.sv
// Turns an unsigned quotient bit and remainder into a floored fold or wrap
// of one coordinate. Depends on abrw_pkg.
module abrw_fold import abrw_pkg::*; (
  input  logic [31:0]        rem,
  input  logic               q_lsb,
  input  logic               val_neg,
  input  logic               size_neg,
  input  logic signed [32:0] size,
  input  logic signed [31:0] lo,
  input  logic               reflect,
  output fold_res_t          res
);

  logic signed [33:0] srem, m, folded, sum;
  logic               differ, rnz, parity;

  // Floored modulo from the magnitude remainder, then the optional mirror.
  always_comb begin
    rnz    = (rem != '0);
    differ = val_neg ^ size_neg;
    srem   = size_neg ? -$signed({2'b00, rem}) : $signed({2'b00, rem});
    if (!rnz) begin
      m = '0;
    end else if (differ) begin
      m = $signed({size[32], size}) - srem;
    end else begin
      m = srem;
    end
    parity = q_lsb ^ (differ & rnz);
    if (reflect && parity && (m != '0)) begin
      folded = $signed({size[32], size}) - m;
    end else begin
      folded = m;
    end
    sum       = folded + $signed({{2{lo[31]}}, lo});
    res.value = sum[31:0];
    res.flip  = reflect & parity;
  end

endmodule

FILE: rtl/area_border_reflect_wrap_top.sv
// Top level of the area border reflect/wrap block: config registers, six
// divider lanes, side pipeline and the merging output stage.
// Depends on abrw_pkg, abrw_if, abrw_div and abrw_fold.
//
// Usage: items enter on in_ch (valid/ready) and results leave on out_ch.
// Each accepted item gives exactly one result after the six 32-stage divider
// lanes (position and target on each axis, one quotient bit per stage) and
// the output register. A new item is taken every cycle unless out_ch stalls.
// The config port (cfg_we, cfg_idx, cfg_wdata) writes one register per
// cycle; write only while no item is in flight.
// Reset clears all valid flags and loads the register reset values; the
// pipeline is empty right after reset.
// When the receiver stalls the whole pipeline holds and in_ch.ready drops,
// so nothing is lost; a waiting result does not block a transfer in the
// same cycle it is taken.
module area_border_reflect_wrap_top import abrw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  abrw_in_if.sink     in_ch,
  abrw_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_wdata
);

  logic signed [31:0] min_r [3];
  logic signed [31:0] max_r [3];
  logic [1:0]         policy_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r[0] <= '0; max_r[0] <= 32'sd65536000;
      min_r[1] <= '0; max_r[1] <= 32'sd65536000;
      min_r[2] <= '0; max_r[2] <= '0;
      policy_r <= POL_REFLECT;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MIN_X:  min_r[0] <= cfg_wdata;
        REG_MAX_X:  max_r[0] <= cfg_wdata;
        REG_MIN_Y:  min_r[1] <= cfg_wdata;
        REG_MAX_Y:  max_r[1] <= cfg_wdata;
        REG_MIN_Z:  min_r[2] <= cfg_wdata;
        REG_MAX_Z:  max_r[2] <= cfg_wdata;
        REG_POLICY: policy_r <= cfg_wdata[1:0];
        default:    ;
      endcase
    end
  end

  logic en;
  logic out_valid_r;
  out_item_t out_data_r;

  // The pipeline moves whenever the output register is free or drained.
  assign en           = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  logic signed [31:0] pos_in [3];
  logic signed [31:0] tgt_in [3];
  logic signed [31:0] vel_in [3];
  axis_side_t         axis_in [3];
  side_t              side_in;

  always_comb begin
    pos_in[0] = in_ch.data.pos_x;    pos_in[1] = in_ch.data.pos_y;
    pos_in[2] = in_ch.data.pos_z;
    tgt_in[0] = in_ch.data.target_x; tgt_in[1] = in_ch.data.target_y;
    tgt_in[2] = in_ch.data.target_z;
    vel_in[0] = in_ch.data.vel_x;    vel_in[1] = in_ch.data.vel_y;
    vel_in[2] = in_ch.data.vel_z;
  end

  logic [31:0] prem [3];
  logic [31:0] trem [3];
  logic        pq   [3];
  logic        tq   [3];
  side_t       side_r [DIV_STAGES];
  fold_res_t   pres [3];
  fold_res_t   tres [3];

  // One pair of divider lanes per axis.
  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [32:0] size, pval, tval;
    logic [31:0]        size_mag, pmag, tmag;

    always_comb begin
      size = $signed({max_r[a][31], max_r[a]}) - $signed({min_r[a][31], min_r[a]});
      pval = $signed({pos_in[a][31], pos_in[a]}) - $signed({min_r[a][31], min_r[a]});
      tval = $signed({tgt_in[a][31], tgt_in[a]}) - $signed({min_r[a][31], min_r[a]});
      size_mag = size[32] ? 32'(-size) : size[31:0];
      pmag     = pval[32] ? 32'(-pval) : pval[31:0];
      tmag     = tval[32] ? 32'(-tval) : tval[31:0];
      axis_in[a].outside   = (pos_in[a] < min_r[a]) || (max_r[a] < pos_in[a]);
      axis_in[a].size_zero = (size == '0);
      axis_in[a].size_neg  = size[32];
      axis_in[a].pos_neg   = pval[32];
      axis_in[a].tgt_neg   = tval[32];
      axis_in[a].size      = size;
      axis_in[a].lo        = min_r[a];
      axis_in[a].vel       = vel_in[a];
    end

    abrw_div u_pdiv (
      .clk(clk), .en(en), .num(pmag), .den(size_mag), .rem(prem[a]), .q_lsb(pq[a])
    );
    abrw_div u_tdiv (
      .clk(clk), .en(en), .num(tmag), .den(size_mag), .rem(trem[a]), .q_lsb(tq[a])
    );

    abrw_fold u_pfold (
      .rem(prem[a]), .q_lsb(pq[a]),
      .val_neg(side_r[DIV_STAGES-1].axis[a].pos_neg),
      .size_neg(side_r[DIV_STAGES-1].axis[a].size_neg),
      .size(side_r[DIV_STAGES-1].axis[a].size),
      .lo(side_r[DIV_STAGES-1].axis[a].lo),
      .reflect(side_r[DIV_STAGES-1].policy == POL_REFLECT),
      .res(pres[a])
    );
    abrw_fold u_tfold (
      .rem(trem[a]), .q_lsb(tq[a]),
      .val_neg(side_r[DIV_STAGES-1].axis[a].tgt_neg),
      .size_neg(side_r[DIV_STAGES-1].axis[a].size_neg),
      .size(side_r[DIV_STAGES-1].axis[a].size),
      .lo(side_r[DIV_STAGES-1].axis[a].lo),
      .reflect(side_r[DIV_STAGES-1].policy == POL_REFLECT),
      .res(tres[a])
    );
  end

  // Assemble the side data that travels beside the dividers.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      side_in.axis[a] = axis_in[a];
    end
    side_in.heading = in_ch.data.heading;
    side_in.policy  = policy_r;
  end

  // Side data and valid flags travel in step with the dividers.
  logic [DIV_STAGES-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_STAGES-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int s = 1; s < DIV_STAGES; s++) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  // Original coordinates, carried along for pass-through.
  logic signed [31:0] pos_keep_r [DIV_STAGES][3];
  logic signed [31:0] tgt_keep_r [DIV_STAGES][3];

  always_ff @(posedge clk) begin
    if (en) begin
      pos_keep_r[0] <= pos_in;
      tgt_keep_r[0] <= tgt_in;
      for (int s = 1; s < DIV_STAGES; s++) begin
        pos_keep_r[s] <= pos_keep_r[s-1];
        tgt_keep_r[s] <= tgt_keep_r[s-1];
      end
    end
  end

  function automatic logic signed [31:0] pos_fwd(input int a);
    return pos_keep_r[DIV_STAGES-1][a];
  endfunction

  function automatic logic signed [31:0] tgt_fwd(input int a);
    return tgt_keep_r[DIV_STAGES-1][a];
  endfunction

  function automatic logic signed [33:0] sat34(input logic signed [33:0] v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // Merge stage: pick per-axis results, flip velocity and heading, set the error flag.
  side_t              sd;
  out_item_t          mrg;
  logic signed [31:0] npos [3];
  logic signed [31:0] ntgt [3];
  logic signed [31:0] nvel [3];
  logic               flip [3];
  logic signed [33:0] h0, h1, h2, hx, hy;
  logic               any_out;

  always_comb begin
    sd      = side_r[DIV_STAGES-1];
    any_out = 1'b0;
    for (int a = 0; a < 3; a++) begin
      npos[a] = pos_fwd(a);
      ntgt[a] = tgt_fwd(a);
      nvel[a] = sd.axis[a].vel;
      flip[a] = 1'b0;
      any_out = any_out | sd.axis[a].outside;
      if (sd.axis[a].outside &&
          (sd.policy == POL_REFLECT || sd.policy == POL_WRAP)) begin
        if (sd.axis[a].size_zero) begin
          npos[a] = sd.axis[a].lo;
          ntgt[a] = sd.axis[a].lo;
        end else begin
          npos[a] = pres[a].value;
          ntgt[a] = tres[a].value;
          flip[a] = pres[a].flip;
        end
      end
      if (flip[a]) begin
        nvel[a] = (sd.axis[a].vel == 32'sh80000000) ? 32'sh7fffffff : -sd.axis[a].vel;
      end
    end
    h0 = $signed({{2{sd.heading[31]}}, sd.heading});
    hx = HEAD_180 - h0;
    h1 = flip[0] ? sat34(hx) : h0;
    hy = -h1;
    h2 = flip[1] ? sat34(hy) : h1;
    mrg.new_pos_x     = npos[0];
    mrg.new_pos_y     = npos[1];
    mrg.new_pos_z     = npos[2];
    mrg.new_target_x  = ntgt[0];
    mrg.new_target_y  = ntgt[1];
    mrg.new_target_z  = ntgt[2];
    mrg.new_vel_x     = nvel[0];
    mrg.new_vel_y     = nvel[1];
    mrg.new_vel_z     = nvel[2];
    mrg.new_heading   = h2[31:0];
    mrg.outside_error = (sd.policy == POL_ERROR) && any_out;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= mrg;
    end
  end

endmodule
